// ===== design/assert_macros.svh =====
// Assertion macros used by the tap generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/gktg_pkg.sv =====
// Types, constants and the exp2 root table of the tap generator.
`default_nettype none
package gktg_pkg;

   localparam int SIDE_TAPS_DEF = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int DIV_NUM_W     = 49;
   localparam int DIV_DEN_W     = 38;
   localparam int RAW_W         = 33;
   localparam int TOT_W         = 38;

   localparam logic [23:0] OFF_MAX     = 24'h7FFFFF;
   localparam logic [15:0] WGT_MAX     = 16'hFFFF;
   localparam logic [21:0] EXP_CAP     = 22'd3145728;  // 48.0 in Q16
   localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
   localparam logic [7:0]  EXP_N_LIMIT = 8'd40;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [15:0] deviation;
   } req_type;

   typedef struct packed {
      logic [3:0]         tap_index;
      logic signed [23:0] offset_x;
      logic signed [23:0] offset_y;
      logic [15:0]        weight;
      logic               last_tap;
   } rsp_type;

   // classified request as it waits between front and back
   typedef struct packed {
      logic [15:0] mag_x;
      logic        neg_x;
      logic [15:0] mag_y;
      logic        neg_y;
      logic [12:0] width;
      logic [12:0] height;
      logic [31:0] d2;
      logic [31:0] s2;
      logic        impulse;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AMUL, ST_ADIV, ST_AWAIT, ST_EWAIT, ST_WGO, ST_WWAIT,
      ST_XGO, ST_XWAIT, ST_YGO, ST_YWAIT, ST_PUSH
   } back_state_type;

   typedef enum logic [2:0] {
      E_IDLE, E_MUL, E_SPLIT, E_STEP, E_FIN
   } exp_state_type;

   typedef logic [16:0][31:0] exp_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // entry k is 2^32 * 2^(-2^-k), built from repeated floor square roots
   function automatic exp_tab_type build_tab();
      exp_tab_type t;
      t    = '0;
      t[1] = 32'(isqrt64(64'h8000_0000_0000_0000));
      for (int k = 1; k < 16; k++) begin
         t[k+1] = 32'(isqrt64({t[k], 32'd0}));
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_tab();

endpackage
`default_nettype wire

// ===== design/gaussian_kernel_tap_generator_top.sv =====
// Top level of the gaussian kernel tap generator.
// Requests are processed one at a time; the job queue lets intake run ahead meanwhile.
// Speed is set by the single shared divider (3 divides per tap, 2 with zero deviation,
//   1 per side weight) and by the exp unit.
// Reset: synchronous, active high; clears queues and control state only.
`default_nettype none
module gaussian_kernel_tap_generator_top
   import gktg_pkg::*;
#(
   parameter int SIDE_TAPS = SIDE_TAPS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);
   // front to back: classified request words
   logic    job_push, job_full, job_pop, job_empty;
   job_type job_wr, job_rd;

   // back to result queue: one word per tap
   logic    out_push, out_full;
   rsp_type out_word;

   assign req_full = job_full;

   gktg_front u_front (
      .req_push(req_push), .req_data(req_data), .job_full(job_full),
      .job_push(job_push), .job_word(job_wr)
   );

   // short queue lets intake run ahead while the back part works
   gktg_fifo #(.WIDTH($bits(job_type)), .DEPTH(QUEUE_DEPTH)) u_job_q (
      .clock(clock), .reset(reset), .push(job_push), .wdata(job_wr),
      .full(job_full), .pop(job_pop), .rdata(job_rd), .empty(job_empty)
   );

   gktg_back #(.SIDE_TAPS(SIDE_TAPS)) u_back (
      .clock(clock), .reset(reset), .job_empty(job_empty), .job_in(job_rd),
      .job_pop(job_pop), .out_full(out_full), .out_push(out_push),
      .out_word(out_word)
   );

   // result queue decouples tap generation from the consumer's pop
   gktg_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock(clock), .reset(reset), .push(out_push), .wdata(out_word),
      .full(out_full), .pop(rsp_pop), .rdata(rsp_data), .empty(rsp_empty)
   );

endmodule
`default_nettype wire

// ===== design/gktg_fifo.sv =====
// Small register queue used between front and back and at the result side.
`default_nettype none
module gktg_fifo
   import gktg_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== design/gktg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module gktg_div
   import gktg_pkg::*;
#(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [NUM_W-1:0] quot_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};
   assign busy  = busy_ff;
   assign done  = done_ff;
   assign quot  = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         rem_ff  <= '0;
         quot_ff <= num;
         den_ff  <= den;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_ff <= {quot_ff[NUM_W-2:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== design/gktg_exp.sv =====
// exp(-a) in Q1.32 from a in Q16, via 2^-f root products and a final shift.
`default_nettype none
module gktg_exp
   import gktg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] a,
   output logic                      busy,
   output logic                      done,
   output logic [RAW_W-1:0]          res
);
   exp_state_type state_ff, state_in;

   logic [21:0]      a_ff;
   logic [52:0]      prod_ff;
   logic [5:0]       n_ff;
   logic [15:0]      f_ff;
   logic [3:0]       cnt_ff;
   logic [RAW_W-1:0] r_ff, res_ff;
   logic             done_ff;

   logic             too_big;
   logic [53:0]      t_sum;
   logic [7:0]       n_c;
   logic [4:0]       tab_idx;
   logic [64:0]      mul_c;
   logic [64:0]      rnd_c;
   logic [RAW_W-1:0] r_step;

   assign busy = (state_ff != E_IDLE);
   assign done = done_ff;
   assign res  = res_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE:  if (start && !too_big) state_in = E_MUL;
         E_MUL:   state_in = E_SPLIT;
         E_SPLIT: state_in = (n_c >= EXP_N_LIMIT) ? E_IDLE : E_STEP;
         E_STEP:  if (cnt_ff == 4'd15) state_in = E_FIN;
         E_FIN:   state_in = E_IDLE;
         default: state_in = E_IDLE;
      endcase
   end

   // datapath terms
   always_comb begin
      too_big = (a > DIV_NUM_W'(EXP_CAP));
      t_sum   = 54'(prod_ff) + 54'(32'h2000_0000);
      n_c     = t_sum[53:46];
      tab_idx = 5'(cnt_ff) + 5'd1;
      mul_c   = 65'(r_ff) * 65'(EXP_TAB[tab_idx]);
      rnd_c   = mul_c + 65'(32'h8000_0000);
      r_step  = f_ff[15] ? rnd_c[64:32] : r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= ((state_ff == E_IDLE) && start && too_big) ||
                     ((state_ff == E_SPLIT) && (n_c >= EXP_N_LIMIT)) ||
                     (state_ff == E_FIN);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         E_IDLE: begin
            a_ff   <= a[21:0];
            res_ff <= '0;
         end
         E_MUL: prod_ff <= a_ff * LOG2E_Q30;
         E_SPLIT: begin
            n_ff   <= n_c[5:0];
            f_ff   <= t_sum[45:30];
            cnt_ff <= '0;
            r_ff   <= RAW_W'(64'h1_0000_0000);
            res_ff <= '0;
         end
         E_STEP: begin
            r_ff   <= r_step;
            f_ff   <= {f_ff[14:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
         end
         E_FIN:   res_ff <= r_ff >> n_ff;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/gktg_front.sv =====
// Request intake: magnitudes, signs, squared terms and size clamp.
`default_nettype none
module gktg_front
   import gktg_pkg::*;
(
   input  wire logic    req_push,
   input  wire req_type req_data,
   input  wire logic    job_full,
   output logic         job_push,
   output job_type      job_word
);
   logic neg_x, neg_y;
   logic [15:0] mag_x, mag_y;

   assign neg_x = req_data.dir_x[15];
   assign neg_y = req_data.dir_y[15];
   assign mag_x = neg_x ? 16'(-req_data.dir_x) : 16'(req_data.dir_x);
   assign mag_y = neg_y ? 16'(-req_data.dir_y) : 16'(req_data.dir_y);

   assign job_push = req_push & ~job_full;

   always_comb begin
      job_word.mag_x   = mag_x;
      job_word.neg_x   = neg_x;
      job_word.mag_y   = mag_y;
      job_word.neg_y   = neg_y;
      job_word.width   = (req_data.image_width == '0) ? 13'd1 : req_data.image_width;
      job_word.height  = (req_data.image_height == '0) ? 13'd1 : req_data.image_height;
      job_word.d2      = (32'(mag_x) * 32'(mag_x)) + (32'(mag_y) * 32'(mag_y));
      job_word.s2      = 32'(req_data.deviation) * 32'(req_data.deviation);
      job_word.impulse = (req_data.deviation == '0);
   end

endmodule
`default_nettype wire

// ===== design/gktg_back.sv =====
// Tap sequencer: raw weights, normalization and offsets on a shared divider.
`default_nettype none
`include "assert_macros.svh"
module gktg_back
   import gktg_pkg::*;
#(
   parameter int SIDE_TAPS = SIDE_TAPS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_empty,
   input  wire job_type job_in,
   output logic         job_pop,
   input  wire logic    out_full,
   output logic         out_push,
   output rsp_type      out_word
);
   localparam int DIST_W  = $clog2(SIDE_TAPS);
   localparam int TAP_CNT = 2 * SIDE_TAPS - 1;
   localparam int KW      = $clog2(TAP_CNT);
   localparam logic [DIST_W-1:0] LAST_I = DIST_W'(SIDE_TAPS - 1);
   localparam logic [KW-1:0]     LAST_K = KW'(TAP_CNT - 1);

   back_state_type state_ff, state_in;

   job_type                job_ff;
   logic [DIST_W-1:0]      idx_ff;
   logic [KW-1:0]          k_ff;
   logic [DIV_NUM_W-1:0]   num_ff;
   logic [TOT_W-1:0]       total_ff;
   logic [RAW_W-1:0]       raw_ff [SIDE_TAPS];
   logic [15:0]            wgt_ff;
   logic [23:0]            offx_ff, offy_ff;

   logic                   div_start, div_busy, div_done;
   logic [DIV_NUM_W-1:0]   div_num, div_quot;
   logic [DIV_DEN_W-1:0]   div_den;
   logic                   exp_start, exp_busy, exp_done;
   logic [RAW_W-1:0]       exp_res;

   logic                   mirror_c;
   logic [DIST_W-1:0]      dist_c;
   logic [2*DIST_W-1:0]    ii_c;
   logic [2*DIST_W+31:0]   aprod_c;
   logic [DIV_NUM_W-1:0]   anum_c, wnum_c, xnum_c, ynum_c;
   logic [DIST_W+15:0]     xm_c, ym_c;
   logic [23:0]            qsat_c;
   logic [15:0]            wsat_c;

   gktg_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .busy(div_busy), .done(div_done), .quot(div_quot)
   );

   gktg_exp u_exp (
      .clock(clock), .reset(reset), .start(exp_start), .a(div_quot),
      .busy(exp_busy), .done(exp_done), .res(exp_res)
   );

   // datapath terms
   always_comb begin
      mirror_c = (k_ff >= KW'(SIDE_TAPS));
      dist_c   = mirror_c ? DIST_W'(k_ff - KW'(SIDE_TAPS - 1)) : DIST_W'(k_ff);
      ii_c     = idx_ff * idx_ff;
      aprod_c  = ii_c * job_ff.d2;
      anum_c   = DIV_NUM_W'({aprod_c, 7'd0});
      wnum_c   = {raw_ff[dist_c], 16'd0} + DIV_NUM_W'(total_ff[TOT_W-1:1]);
      xm_c     = job_ff.mag_x * dist_c;
      ym_c     = job_ff.mag_y * dist_c;
      xnum_c   = DIV_NUM_W'({xm_c, 4'd0}) + DIV_NUM_W'(job_ff.width[12:1]);
      ynum_c   = DIV_NUM_W'({ym_c, 4'd0}) + DIV_NUM_W'(job_ff.height[12:1]);
      qsat_c   = (div_quot > DIV_NUM_W'(OFF_MAX)) ? OFF_MAX : div_quot[23:0];
      wsat_c   = (div_quot > DIV_NUM_W'(WGT_MAX)) ? WGT_MAX : div_quot[15:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!job_empty) state_in = job_in.impulse ? ST_WGO : ST_AMUL;
         ST_AMUL:  state_in = ST_ADIV;
         ST_ADIV:  state_in = ST_AWAIT;
         ST_AWAIT: if (div_done) state_in = ST_EWAIT;
         ST_EWAIT: if (exp_done) state_in = (idx_ff == LAST_I) ? ST_WGO : ST_AMUL;
         ST_WGO:   state_in = job_ff.impulse ? ST_XGO : ST_WWAIT;
         ST_WWAIT: if (div_done) state_in = ST_XGO;
         ST_XGO:   state_in = ST_XWAIT;
         ST_XWAIT: if (div_done) state_in = ST_YGO;
         ST_YGO:   state_in = ST_YWAIT;
         ST_YWAIT: if (div_done) state_in = ST_PUSH;
         ST_PUSH:  if (!out_full) state_in = (k_ff == LAST_K) ? ST_IDLE : ST_WGO;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      div_start = 1'b0;
      div_num   = anum_c;
      div_den   = DIV_DEN_W'(job_ff.s2);
      exp_start = 1'b0;
      job_pop   = 1'b0;
      out_push  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  job_pop = ~job_empty;
         ST_ADIV: begin
            div_start = 1'b1;
            div_num   = num_ff;
         end
         ST_AWAIT: exp_start = div_done;
         ST_WGO: begin
            div_start = ~job_ff.impulse;
            div_num   = wnum_c;
            div_den   = DIV_DEN_W'(total_ff);
         end
         ST_XGO: begin
            div_start = 1'b1;
            div_num   = xnum_c;
            div_den   = DIV_DEN_W'(job_ff.width);
         end
         ST_YGO: begin
            div_start = 1'b1;
            div_num   = ynum_c;
            div_den   = DIV_DEN_W'(job_ff.height);
         end
         ST_PUSH:  out_push = ~out_full;
         default:  ;
      endcase
   end

   always_comb begin
      out_word.tap_index = 4'(k_ff);
      out_word.offset_x  = offx_ff;
      out_word.offset_y  = offy_ff;
      out_word.weight    = wgt_ff;
      out_word.last_tap  = (k_ff == LAST_K);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            job_ff   <= job_in;
            idx_ff   <= '0;
            k_ff     <= '0;
            total_ff <= '0;
         end
         ST_AMUL: num_ff <= anum_c;
         ST_EWAIT: begin
            if (exp_done) begin
               raw_ff[idx_ff] <= exp_res;
               total_ff <= total_ff + ((idx_ff == '0) ? TOT_W'(exp_res)
                                                      : TOT_W'({exp_res, 1'b0}));
               if (idx_ff != LAST_I) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
         end
         ST_WGO: begin
            if (job_ff.impulse) begin
               wgt_ff <= (dist_c == '0) ? WGT_MAX : 16'd0;
            end
         end
         ST_WWAIT: if (div_done) wgt_ff <= wsat_c;
         ST_XWAIT: begin
            if (div_done) begin
               offx_ff <= (job_ff.neg_x ^ mirror_c) ? 24'(-qsat_c) : qsat_c;
            end
         end
         ST_YWAIT: begin
            if (div_done) begin
               offy_ff <= (job_ff.neg_y ^ mirror_c) ? 24'(-qsat_c) : qsat_c;
            end
         end
         ST_PUSH: begin
            if (!out_full && k_ff != LAST_K) begin
               k_ff <= k_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   `ASSERT_IMPLIES(a_push_room, clock, reset, out_push, !out_full, "push into full result queue")
   `ASSERT_NEXT(a_last_idle, clock, reset, out_push && out_word.last_tap, state_ff == ST_IDLE, "no idle after last tap")
   `ASSERT_IMPLIES(a_div_free, clock, reset, div_start, !div_busy, "divider started while busy")
   `ASSERT_IMPLIES(a_exp_free, clock, reset, exp_start, !exp_busy, "exp unit started while busy")
   `ASSERT_IMPLIES(a_exp_wait, clock, reset, exp_done, state_ff == ST_EWAIT, "exp result not awaited")

endmodule
`default_nettype wire
